[sv/csvfs_pkg.sv]
// -----------------------------------------------------------------------------
// csvfs_pkg
// Shared constants and types for the CSV field splitter: special bytes,
// result kinds, register map and default limits.
// -----------------------------------------------------------------------------
package csvfs_pkg;

    // Special characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Delimiter after reset: ','
    localparam logic [7:0] DELIM_RESET = 8'h2C;

    // Default counter limits
    localparam int unsigned MAX_COLUMNS_DEF = 255;
    localparam int unsigned MAX_ROWS_DEF    = 65535;

    // Register map (word index taken from paddr[2])
    localparam logic REG_DELIMITER = 1'b0;

    // Input request opcode (carried in tuser)
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_EOT  = 1'b1
    } op_t;

    // Result kind (carried in tuser)
    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2
    } kind_t;

endpackage

[sv/csv_field_splitter.sv]
// -----------------------------------------------------------------------------
// csv_field_splitter
// Streaming CSV splitter: quote tracking, delimiter split, row ends with
// empty-row suppression, saturating column/row counters and widest row.
// -----------------------------------------------------------------------------
// A result is registered and appears on the master side in the cycle after its
// byte is accepted. Throughput: one request per cycle while the output is not
// stalled; the only loop is the parser state update from the accepted byte.
// Reset (aresetn low, synchronous): parser state and counters cleared,
// output empty, delimiter back to ','. No clearing pass is needed.
module csv_field_splitter #(
    parameter int unsigned MAX_COLUMNS = csvfs_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS    = csvfs_pkg::MAX_ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic [0:0]  s_tuser,    // [0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [7:0] field_char, [15:8] column_index,
                                    // [31:16] row_index, [39:32] max_columns
    output logic [1:0]  m_tuser,    // [1:0] kind
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import csvfs_pkg::*;

    // counter widths follow the limits
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int RW = $clog2(MAX_ROWS);
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

    // configuration and parser state
    logic [7:0]    delim_reg;
    logic          in_quote_reg, in_quote_next;
    logic          quote_pend_reg, quote_pend_next;
    logic          line_bytes_reg, line_bytes_next;
    logic          row_content_reg, row_content_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] widest_reg, widest_next;

    // output register
    logic          m_valid_reg;
    kind_t         kind_reg;
    logic [7:0]    char_reg;
    logic [7:0]    col_out_reg;
    logic [15:0]   row_out_reg;
    logic [7:0]    max_out_reg;

    // per-request working signals
    logic          s_fire;
    op_t           op;
    logic [7:0]    ch;
    logic          take_plain;
    logic          res_valid;
    kind_t         res_kind;
    logic [7:0]    res_char;
    logic [CW-1:0] fields;
    logic [CW-1:0] widest_upd;
    logic [CW+7:0] col_ext;
    logic [RW+15:0] row_ext;
    logic [CW+7:0] max_ext;

    // handshakes
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser[0]);
    assign ch       = s_tdata;

    // widest row including the row being closed
    assign fields     = col_reg + CW'(1);
    assign widest_upd = (fields > widest_reg) ? fields : widest_reg;

    // parser next state and result
    always_comb begin
        in_quote_next    = in_quote_reg;
        quote_pend_next  = quote_pend_reg;
        line_bytes_next  = line_bytes_reg;
        row_content_next = row_content_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        widest_next      = widest_reg;
        take_plain       = 1'b0;
        res_valid        = 1'b0;
        res_kind         = KIND_CHAR;
        res_char         = '0;

        if (s_fire) begin
            if (op == OP_EOT) begin
                // flush a pending row, then clear everything
                if (line_bytes_reg) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ROW_END;
                end
                in_quote_next    = 1'b0;
                quote_pend_next  = 1'b0;
                line_bytes_next  = 1'b0;
                row_content_next = 1'b0;
                col_next         = '0;
                row_next         = '0;
                widest_next      = '0;
            end else begin
                if (in_quote_reg) begin
                    if (quote_pend_reg) begin
                        quote_pend_next = 1'b0;
                        if (ch == CH_QUOTE) begin
                            // doubled quote: one literal quote
                            line_bytes_next  = 1'b1;
                            row_content_next = 1'b1;
                            res_valid        = 1'b1;
                            res_char         = ch;
                        end else begin
                            // quoting closed, byte handled as unquoted
                            in_quote_next = 1'b0;
                            take_plain    = 1'b1;
                        end
                    end else begin
                        line_bytes_next = 1'b1;
                        if (ch == CH_QUOTE) begin
                            quote_pend_next = 1'b1;
                        end else begin
                            row_content_next = 1'b1;
                            res_valid        = 1'b1;
                            res_char         = ch;
                        end
                    end
                end else begin
                    take_plain = 1'b1;
                end

                // unquoted byte handling
                if (take_plain) begin
                    if (ch == CH_LF) begin
                        col_next        = '0;
                        line_bytes_next = 1'b0;
                        if (row_content_reg) begin
                            res_valid        = 1'b1;
                            res_kind         = KIND_ROW_END;
                            widest_next      = widest_upd;
                            row_content_next = 1'b0;
                            if (row_reg < ROW_LAST) begin
                                row_next = row_reg + RW'(1);
                            end
                        end
                    end else begin
                        line_bytes_next = 1'b1;
                        priority if (ch == CH_QUOTE) begin
                            in_quote_next = 1'b1;
                        end else if (ch == delim_reg) begin
                            row_content_next = 1'b1;
                            res_valid        = 1'b1;
                            res_kind         = KIND_FIELD_END;
                            if (col_reg < COL_LAST) begin
                                col_next = col_reg + CW'(1);
                            end
                        end else if (ch != CH_CR) begin
                            row_content_next = 1'b1;
                            res_valid        = 1'b1;
                            res_char         = ch;
                        end
                    end
                end
            end
        end
    end

    // outputs masked to their field widths
    assign col_ext = {8'd0, col_reg};
    assign row_ext = {16'd0, row_reg};
    assign max_ext = (res_kind == KIND_ROW_END) ? {8'd0, widest_upd} : {8'd0, widest_reg};

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quote_reg    <= 1'b0;
            quote_pend_reg  <= 1'b0;
            line_bytes_reg  <= 1'b0;
            row_content_reg <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            widest_reg      <= '0;
        end else begin
            in_quote_reg    <= in_quote_next;
            quote_pend_reg  <= quote_pend_next;
            line_bytes_reg  <= line_bytes_next;
            row_content_reg <= row_content_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            widest_reg      <= widest_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= res_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && res_valid) begin
            kind_reg    <= res_kind;
            char_reg    <= res_char;
            col_out_reg <= col_ext[7:0];
            row_out_reg <= row_ext[15:0];
            max_out_reg <= max_ext[7:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {max_out_reg, row_out_reg, col_out_reg, char_reg};

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= DELIM_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DELIMITER)) begin
            delim_reg <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DELIMITER) ? {24'd0, delim_reg} : 32'd0;

`ifndef SYNTH
    // a pending quote only exists inside a quoted section
    a_pend_in_quote: assert property (@(posedge aclk) disable iff (!aresetn)
        quote_pend_reg |-> in_quote_reg)
        else $error("quote pending outside quotes");

    // column counter never passes its saturation point
    a_col_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_LAST)
        else $error("column counter beyond limit");

    // end of text leaves the parser cleared
    a_eot_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && op == OP_EOT) |=>
            (row_reg == '0 && widest_reg == '0 && !line_bytes_reg && !in_quote_reg))
        else $error("state not cleared after end of text");
`endif

endmodule
